>>> design/qee_pkg.sv
// Shared types, constants and sizes for the quadrature encoder emulator.
`timescale 1ns / 1ps
`default_nettype none

package qee_pkg;

  // Request function codes
  localparam logic FuncFeed = 1'b0;
  localparam logic FuncTick = 1'b1;

  localparam int DeltaW   = 16;
  localparam int SensW    = 13;
  localparam int PendingW = 12;
  localparam int CarryW   = 9;
  localparam int FracBits = 8;

  localparam int MaxBacklog = 1024;
  localparam int MaxDelta   = 32767;

  localparam logic [SensW-1:0] SensReset = SensW'(256);

  // Product of the clamped delta and the gain, plus the carry, with headroom.
  localparam int AccW     = DeltaW + SensW + 1;
  localparam int QuotW    = AccW - FracBits;
  localparam int BacklogW = $clog2(MaxBacklog + 1) + 1;
  localparam int SumW     = ((BacklogW > QuotW) ? BacklogW : QuotW) + 1;

  // Gray-code levels, bit i holds the level at phase i
  localparam logic [3:0] LevelATab = 4'b0110;
  localparam logic [3:0] LevelBTab = 4'b1100;

  typedef struct packed {
    logic                       stepped;
    logic                       level_a;
    logic                       level_b;
    logic signed [PendingW-1:0] pending_steps;
  } result_t;

endpackage

`default_nettype wire

>>> design/qee_step.sv
// Motion scaling, backlog and phase state with next-result logic.
`timescale 1ns / 1ps
`default_nettype none

module qee_step (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 fire_i,
  input  wire logic                                 func_i,
  input  wire logic signed [qee_pkg::DeltaW-1:0]    delta_i,
  input  wire logic        [qee_pkg::SensW-1:0]     sens_i,
  output qee_pkg::result_t                          res_o
);
  import qee_pkg::*;

  localparam logic signed [DeltaW-1:0] DeltaMin = -DeltaW'(MaxDelta);
  localparam logic signed [SumW-1:0]   SumMax   = SumW'(MaxBacklog);
  localparam logic signed [SumW-1:0]   SumMin   = -SumW'(MaxBacklog);

  logic signed [CarryW-1:0]   carry_q, carry_d;
  logic signed [BacklogW-1:0] backlog_q, backlog_d;
  logic        [1:0]          phase_q, phase_d;

  logic signed [DeltaW-1:0]   delta_c;
  logic signed [AccW-1:0]     prod;
  logic signed [AccW-1:0]     acc;
  logic                       fix;
  logic signed [QuotW-1:0]    quot;
  logic signed [SumW-1:0]     sum;
  logic signed [BacklogW-1:0] bl_sat;
  logic signed [31:0]         bl_wide;
  logic                       stepped;

  assign delta_c = (delta_i < DeltaMin) ? DeltaMin : delta_i;
  assign prod    = AccW'(delta_c) * $signed({1'b0, sens_i});
  assign acc     = prod + AccW'(carry_q);

  // Truncate toward zero: floor, then bump a negative value with a remainder
  assign fix  = acc[AccW-1] & (|acc[FracBits-1:0]);
  assign quot = $signed(acc[AccW-1:FracBits]) + $signed(QuotW'(fix));
  assign sum  = SumW'(backlog_q) + SumW'(quot);

  always_comb begin
    if (sum > SumMax) begin
      bl_sat = BacklogW'(SumMax);
    end else if (sum < SumMin) begin
      bl_sat = BacklogW'(SumMin);
    end else begin
      bl_sat = BacklogW'(sum);
    end
  end

  always_comb begin
    carry_d   = carry_q;
    backlog_d = backlog_q;
    phase_d   = phase_q;
    stepped   = 1'b0;
    case (func_i)
      FuncFeed: begin
        if (delta_i != '0) begin
          carry_d   = {fix, acc[FracBits-1:0]};
          backlog_d = bl_sat;
        end
      end
      FuncTick: begin
        if (backlog_q > 0) begin
          phase_d   = phase_q + 2'd1;
          backlog_d = backlog_q - BacklogW'(1);
          stepped   = 1'b1;
        end else if (backlog_q < 0) begin
          phase_d   = phase_q - 2'd1;
          backlog_d = backlog_q + BacklogW'(1);
          stepped   = 1'b1;
        end
      end
      default: begin
        stepped = 1'b0;
      end
    endcase
  end

  assign bl_wide              = 32'(backlog_d);
  assign res_o.stepped        = stepped;
  assign res_o.level_a        = LevelATab[phase_d];
  assign res_o.level_b        = LevelBTab[phase_d];
  assign res_o.pending_steps  = bl_wide[PendingW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q   <= '0;
      backlog_q <= '0;
      phase_q   <= '0;
    end else if (fire_i) begin
      carry_q   <= carry_d;
      backlog_q <= backlog_d;
      phase_q   <= phase_d;
    end
  end

endmodule

`default_nettype wire

>>> design/quadrature_encoder_emulator_core.sv
// Top level: request register, step logic, result register and gain register.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    func_i, motion_delta_i
//   out      output     out_valid_o / out_ready_i  stepped_o, level_a_o, level_b_o,
//                                                  pending_steps_o
//   cfg      input      cfg_valid_i / cfg_ready_o  sensitivity_q8_i
//
// One request per cycle sustained unless the result stalls.
// The step logic (one multiply, carry fix-up, saturating add) runs between the
// request register and the result register. State updates when a result is loaded.
// A stalled result holds the request register; in_ready_o drops only when both are full.
// Reset clears state, the valid flags and sets the gain to 256; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_encoder_emulator_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire logic                                 func_i,
  input  wire logic signed [qee_pkg::DeltaW-1:0]    motion_delta_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  output      logic                                 stepped_o,
  output      logic                                 level_a_o,
  output      logic                                 level_b_o,
  output      logic signed [qee_pkg::PendingW-1:0]  pending_steps_o,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic        [qee_pkg::SensW-1:0]     sensitivity_q8_i
);
  import qee_pkg::*;

  logic                     in_valid_q;
  logic                     func_q;
  logic signed [DeltaW-1:0] delta_q;
  logic                     out_valid_q;
  result_t                  res_q;
  result_t                  res_d;
  logic [SensW-1:0]         sens_q;
  logic                     advance;
  logic                     fire;

  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  qee_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .func_i  (func_q),
    .delta_i (delta_q),
    .sens_i  (sens_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sens_q      <= SensReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sens_q <= sensitivity_q8_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q  <= func_i;
      delta_q <= motion_delta_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stepped_o       = res_q.stepped;
  assign level_a_o       = res_q.level_a;
  assign level_b_o       = res_q.level_b;
  assign pending_steps_o = res_q.pending_steps;

endmodule

`default_nettype wire

>>> design/qee_checker.sv
// Port-level checks for the quadrature encoder emulator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module qee_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire logic                                 stepped_o,
  input wire logic                                 level_a_o,
  input wire logic                                 level_b_o,
  input wire logic signed [qee_pkg::PendingW-1:0]  pending_steps_o
);
  import qee_pkg::*;

  localparam logic signed [PendingW-1:0] PendMax = PendingW'(MaxBacklog);
  localparam logic signed [PendingW-1:0] PendMin = -PendingW'(MaxBacklog);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({stepped_o, level_a_o, level_b_o, pending_steps_o}))
    else $error("result changed while stalled");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_steps_o <= PendMax && pending_steps_o >= PendMin)
    else $error("backlog out of range");

  a_step_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stepped_o |-> pending_steps_o != PendMax && pending_steps_o != PendMin)
    else $error("step left a full backlog");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request side blocked without a stalled result");

endmodule

bind quadrature_encoder_emulator_core qee_checker u_qee_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the quadrature encoder emulator core.
`timescale 1ns / 1ps

module tb_top;
  import qee_pkg::*;

  typedef enum logic [1:0] {JobReq, JobGain, JobSettle} job_kind_e;

  typedef struct {
    job_kind_e                kind;
    logic                     func;
    logic signed [DeltaW-1:0] delta;
    logic [SensW-1:0]         gain;
  } job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       func = FuncFeed;
  logic signed [DeltaW-1:0]   motion_delta = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       stepped;
  logic                       level_a;
  logic                       level_b;
  logic signed [PendingW-1:0] pending_steps;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [SensW-1:0]           sens = SensReset;

  // predicted encoder state
  int               carry_m = 0;
  int               backlog_m = 0;
  logic [1:0]       phase_m = 2'd0;
  logic [SensW-1:0] gain_m = SensReset;

  job_t    jobs[$];
  result_t levels_due[$];
  int      reqs_taken = 0;
  int      settle_cnt = 0;
  int      idle_cycles = 0;
  int      errors = 0;
  logic    calm;

  assign calm = (reqs_taken >= 600) && (reqs_taken < 900);

  always #5 clk_i = ~clk_i;

  quadrature_encoder_emulator_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .motion_delta_i  (motion_delta),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .stepped_o       (stepped),
    .level_a_o       (level_a),
    .level_b_o       (level_b),
    .pending_steps_o (pending_steps),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .sensitivity_q8_i(sens)
  );

  function automatic result_t encoder_step(logic f, logic signed [DeltaW-1:0] delta);
    result_t r;
    longint  d;
    longint  acc;
    longint  q;
    longint  bl;
    r.stepped = 1'b0;
    if (f == FuncFeed) begin
      d = delta;
      if (d != 0) begin
        if (d < -MaxDelta) d = -MaxDelta;
        acc = longint'(carry_m) + d * longint'(gain_m);
        q = acc / 256;
        carry_m = int'(acc - q * 256);
        bl = longint'(backlog_m) + q;
        if (bl > MaxBacklog) bl = MaxBacklog;
        if (bl < -MaxBacklog) bl = -MaxBacklog;
        backlog_m = int'(bl);
      end
    end else if (backlog_m > 0) begin
      phase_m = phase_m + 2'd1;
      backlog_m--;
      r.stepped = 1'b1;
    end else if (backlog_m < 0) begin
      phase_m = phase_m - 2'd1;
      backlog_m++;
      r.stepped = 1'b1;
    end
    r.level_a = LevelATab[phase_m];
    r.level_b = LevelBTab[phase_m];
    r.pending_steps = backlog_m[PendingW-1:0];
    return r;
  endfunction

  task automatic flag_error(string what, int want, int got);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic add_req(logic f, int delta);
    job_t j;
    j.kind = JobReq;
    j.func = f;
    j.delta = DeltaW'(delta);
    j.gain = '0;
    jobs.push_back(j);
  endtask

  // gain changes only once the pipeline has emptied
  task automatic add_gain(int g);
    job_t j;
    j.kind = JobSettle;
    j.func = FuncFeed;
    j.delta = '0;
    j.gain = '0;
    jobs.push_back(j);
    j.kind = JobGain;
    j.gain = SensW'(g);
    jobs.push_back(j);
  endtask

  function automatic int rand_delta();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: return int'($urandom_range(16)) - 8;
      4, 5:       return int'($urandom_range(800)) - 400;
      6, 7:       return int'($urandom_range(65535)) - 32768;
      8: begin
        case ($urandom_range(4))
          0:       return -32768;
          1:       return 32767;
          2:       return -32767;
          3:       return 1;
          default: return -1;
        endcase
      end
      default:    return 0;
    endcase
  endfunction

  // driver: requests and gain writes from the job queue
  always @(posedge clk_i) begin
    logic                     nv;
    logic                     ncv;
    logic                     nf;
    logic signed [DeltaW-1:0] nd;
    logic [SensW-1:0]         ng;
    job_t                     j;
    nv = in_valid;
    ncv = cfg_valid;
    nf = func;
    nd = motion_delta;
    ng = sens;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        levels_due.push_back(encoder_step(func, motion_delta));
        reqs_taken++;
        nv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        gain_m = sens;
        ncv = 1'b0;
      end
      if (!nv && !ncv && jobs.size() > 0) begin
        j = jobs[0];
        case (j.kind)
          JobReq: begin
            if (calm || $urandom_range(99) >= 14) begin
              nv = 1'b1;
              nf = j.func;
              nd = j.delta;
              void'(jobs.pop_front());
            end
          end
          JobGain: begin
            ncv = 1'b1;
            ng = j.gain;
            void'(jobs.pop_front());
          end
          default: begin
            if (levels_due.size() == 0) begin
              if (settle_cnt >= 4) begin
                settle_cnt = 0;
                void'(jobs.pop_front());
              end else begin
                settle_cnt++;
              end
            end else begin
              settle_cnt = 0;
            end
          end
        endcase
      end
    end
    in_valid <= nv;
    func <= nf;
    motion_delta <= nd;
    cfg_valid <= ncv;
    sens <= ng;
  end

  // monitor: result checks and output backpressure
  always @(posedge clk_i) begin
    result_t want;
    logic    nr;
    nr = 1'b0;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          flag_error("unexpected result, pending_steps", 0, int'(pending_steps));
        end else begin
          want = levels_due.pop_front();
          if (stepped !== want.stepped)
            flag_error("stepped", int'(want.stepped), int'(stepped));
          if (level_a !== want.level_a)
            flag_error("level_a", int'(want.level_a), int'(level_a));
          if (level_b !== want.level_b)
            flag_error("level_b", int'(want.level_b), int'(level_b));
          if (pending_steps !== want.pending_steps)
            flag_error("pending_steps", int'(want.pending_steps), int'(pending_steps));
        end
      end
      nr = calm || ($urandom_range(99) >= 14);
    end
    out_ready <= nr;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 4000) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int gains[8];
    int tick_pct;

    // directed: unit steps, empty-backlog ticks, zero delta, clamping, saturation
    add_gain(256);
    add_req(FuncFeed, 1);
    add_req(FuncTick, 0);
    add_req(FuncTick, -1);
    add_req(FuncFeed, -1);
    add_req(FuncTick, 0);
    add_req(FuncTick, 0);
    add_req(FuncFeed, 0);
    add_req(FuncTick, 0);
    add_req(FuncFeed, -32768);
    add_req(FuncTick, 0);
    add_req(FuncFeed, 32767);
    add_req(FuncTick, 0);
    add_req(FuncFeed, 32767);
    add_req(FuncTick, 0);
    add_gain(0);
    add_req(FuncFeed, 32767);
    add_req(FuncTick, 0);
    add_gain(4096);
    add_req(FuncFeed, -32768);
    add_req(FuncFeed, 32767);
    add_req(FuncTick, 0);
    add_gain(8191);
    add_req(FuncFeed, 32767);
    add_req(FuncFeed, -32768);
    add_req(FuncTick, 0);
    add_gain(1);
    add_req(FuncFeed, 255);
    add_req(FuncFeed, 1);
    add_req(FuncFeed, -200);
    add_req(FuncFeed, -300);

    // random phases, one gain setting each
    gains = '{256, 0, 4096, 8191, 1, 255, 0, 0};
    gains[6] = $urandom_range(4096);
    gains[7] = $urandom_range(8191);
    foreach (gains[p]) begin
      add_gain(gains[p]);
      tick_pct = 30 + $urandom_range(50);
      for (int i = 0; i < 240; i++) begin
        if ($urandom_range(99) < tick_pct)
          add_req(FuncTick, int'($urandom_range(65535)));
        else
          add_req(FuncFeed, rand_delta());
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (jobs.size() > 0 || in_valid || cfg_valid || levels_due.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0 && levels_due.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
